[rtl/core/hkvt_pkg.sv]
// ----------------------------------------------------------------------------
// hkvt_pkg
// types and constants shared by the hashed key-value table
// ----------------------------------------------------------------------------
`default_nettype none
package hkvt_pkg;
  localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] result_value;
  } rsp_t;
endpackage
`default_nettype wire

[rtl/core/hkvt_if.sv]
// ----------------------------------------------------------------------------
// hkvt_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
`default_nettype none
interface hkvt_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/hkvt_hash.sv]
// ----------------------------------------------------------------------------
// hkvt_hash
// murmur3 fmix64 over 32x32 partial products, then bucket reduction by
// restoring shift-subtract, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module hkvt_hash #(
  parameter int BUCKETS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] key,
  input  wire logic [16:0] modulus,
  output logic             done,
  output logic [$clog2(BUCKETS+1)-1:0] bucket
);
  import hkvt_pkg::*;
  localparam int MW = $clog2(BUCKETS+1);

  typedef enum logic [5:0] {
    H_IDLE = 6'b000001, H_M1 = 6'b000010, H_X1 = 6'b000100,
    H_M2 = 6'b001000, H_X2 = 6'b010000, H_DIV = 6'b100000
  } hstate_t;

  hstate_t     state_r, state_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] mul_c;
  logic [1:0]  part_r, part_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mcand;
  logic [63:0] pp;
  logic [5:0]  bit_r, bit_nxt;
  logic [MW:0] rem_r, rem_nxt;
  logic [MW:0] sh;
  logic        done_nxt;

  // three 32x32 products, low 64 bits kept
  always_comb begin
    mcand = v_r;
    mul_c = (state_r == H_M1) ? MIX_MUL_A : MIX_MUL_B;
    case (part_r)
      2'd0: pp = 64'(mcand[31:0]) * 64'(mul_c[31:0]);
      2'd1: pp = {32'(mcand[31:0] * mul_c[63:32]), 32'd0};
      2'd2: pp = {32'(mcand[63:32] * mul_c[31:0]), 32'd0};
      default: pp = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt = v_r;
    part_nxt = part_r;
    acc_nxt = acc_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    done_nxt = 1'b0;
    sh = {rem_r[MW-1:0], v_r[bit_r]};
    case (state_r)
      H_IDLE: if (start) begin
        v_nxt = key ^ (key >> MIX_SHIFT);
        state_nxt = H_M1;
        part_nxt = 2'd0;
        acc_nxt = '0;
      end
      H_M1, H_M2: begin
        acc_nxt = acc_r + pp;
        if (part_r == 2'd2) begin
          v_nxt = acc_r + pp;
          state_nxt = (state_r == H_M1) ? H_X1 : H_X2;
        end
        part_nxt = part_r + 2'd1;
      end
      H_X1: begin
        v_nxt = v_r ^ (v_r >> MIX_SHIFT);
        part_nxt = 2'd0;
        acc_nxt = '0;
        state_nxt = H_M2;
      end
      H_X2: begin
        v_nxt = v_r ^ (v_r >> MIX_SHIFT);
        bit_nxt = 6'd63;
        rem_nxt = '0;
        state_nxt = H_DIV;
      end
      H_DIV: begin
        rem_nxt = (sh >= (MW+1)'(modulus)) ? sh - (MW+1)'(modulus) : sh;
        bit_nxt = bit_r - 6'd1;
        if (bit_r == 6'd0) begin
          state_nxt = H_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done <= done_nxt;
    end
    v_r <= v_nxt;
    part_r <= part_nxt;
    acc_r <= acc_nxt;
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
  end

  assign bucket = rem_r[MW-1:0];
endmodule
`default_nettype wire

[rtl/core/hashed_key_value_table.sv]
// ----------------------------------------------------------------------------
// hashed_key_value_table
// latency: after accept, the hash runs its mix states and 64 divider steps; each way is then
// read and checked in turn until all ways are read or an early hit, then the result goes out
// throughput: one item at a time, the next item is accepted in the cycle after the result is taken
// reset: a clearing pass marks every slot free, with the input held off; the bucket
// count returns to 256
// ----------------------------------------------------------------------------
`default_nettype none
module hashed_key_value_table #(
  parameter int BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hkvt_if.sink      in_ch,
  hkvt_if.source    out_ch,
  hkvt_if.sink      cfg_ch
);
  import hkvt_pkg::*;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW = $clog2(BUCKETS+1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_HASH = 7'b0000010, S_READ = 7'b0000100,
    S_CHECK = 7'b0001000, S_DONE = 7'b0010000, S_OUT = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  req_t          req_r;
  rsp_t          rsp_r;
  logic [8:0]    bcount_r;
  logic [16:0]   modulus;
  logic          hash_done;
  logic [MW-1:0] bucket;
  logic [AW-1:0] base_r;
  logic [WW:0]   way_r;
  logic [WW:0]   hit_r, free_r;
  logic [64:0]   mem_keys [SLOTS];
  logic [63:0]   mem_vals [SLOTS];
  logic [64:0]   rd_kv;
  logic [63:0]   rd_key, rd_val;
  logic          rd_valid;
  logic [AW-1:0] rd_addr, cur_addr;
  logic [AW-1:0] clr_r;
  logic          wr_en;
  logic          key_we;
  logic [64:0]   key_wdata;
  logic [AW-1:0] wr_addr;

  always_comb begin
    modulus = 17'(bcount_r);
    if (bcount_r == 9'd0) modulus = 17'd1;
    if (32'(bcount_r) > BUCKETS) modulus = 17'(BUCKETS);
  end

  hkvt_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_IDLE && in_ch.valid),
    .key(in_ch.payload[127:64]), .modulus(modulus), .done(hash_done),
    .bucket(bucket)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = (state_r == S_IDLE) && !in_ch.valid;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.payload = rsp_r;

  assign cur_addr = base_r + AW'(way_r[WW-1:0]);
  assign rd_addr = cur_addr;
  assign rd_valid = rd_kv[64];
  assign rd_key = rd_kv[63:0];
  assign wr_en = (state_r == S_DONE) && (req_r.mode == MODE_INSERT) &&
                 (hit_r != (WW+1)'(WAYS) || free_r != (WW+1)'(WAYS));

  // key memory carries the slot valid bit on top
  always_comb begin
    key_we = 1'b0;
    key_wdata = {1'b1, req_r.key};
    wr_addr = base_r + AW'((hit_r != (WW+1)'(WAYS)) ? hit_r : free_r);
    if (state_r == S_CLEAR) begin
      key_we = 1'b1;
      key_wdata = '0;
      wr_addr = clr_r;
    end else if (wr_en) begin
      key_we = 1'b1;
    end else if (state_r == S_DONE && req_r.mode == MODE_REMOVE &&
                 hit_r != (WW+1)'(WAYS)) begin
      key_we = 1'b1;
      key_wdata = {1'b0, req_r.key};
    end
  end

  always_ff @(posedge clk) begin
    rd_kv <= mem_keys[rd_addr];
    rd_val <= mem_vals[rd_addr];
    if (key_we) mem_keys[wr_addr] <= key_wdata;
    if (wr_en) mem_vals[wr_addr] <= req_r.value;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(SLOTS-1)) state_nxt = S_IDLE;
      S_IDLE: if (in_ch.valid) state_nxt = S_HASH;
      S_HASH: if (hash_done) state_nxt = S_READ;
      S_READ: state_nxt = S_CHECK;
      S_CHECK: if (way_r == (WW+1)'(WAYS-1) || (rd_valid && rd_key == req_r.key))
        state_nxt = S_DONE;
        else state_nxt = S_READ;
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      bcount_r <= 9'd256;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) bcount_r <= cfg_ch.payload[8:0];
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
    end
    case (state_r)
      S_IDLE: if (in_ch.valid) req_r <= in_ch.payload;
      S_HASH: begin
        base_r <= AW'(32'(bucket) * WAYS);
        way_r <= '0;
        hit_r <= (WW+1)'(WAYS);
        free_r <= (WW+1)'(WAYS);
      end
      S_CHECK: begin
        if (rd_valid && rd_key == req_r.key) begin
          hit_r <= way_r;
          rsp_r.result_value <= rd_val;
        end else if (!rd_valid && free_r == (WW+1)'(WAYS)) begin
          free_r <= way_r;
        end
        way_r <= way_r + 1'b1;
      end
      S_DONE: begin
        if (hit_r != (WW+1)'(WAYS)) begin
          rsp_r.status <= ST_OK;
          if (req_r.mode == MODE_INSERT || req_r.mode == MODE_NONE)
            rsp_r.result_value <= '0;
          if (req_r.mode == MODE_NONE) rsp_r.status <= ST_MISSING;
        end else begin
          rsp_r.result_value <= '0;
          rsp_r.status <= ST_MISSING;
          if (req_r.mode == MODE_INSERT)
            rsp_r.status <= (free_r != (WW+1)'(WAYS)) ? ST_OK : ST_FULL;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[dv/hkvt_checker.sv]
// ----------------------------------------------------------------------------
// hkvt_checker
// watches the request, reply and bucket-count channels of the key-value
// table. Each accepted request goes through a bucketed table model built on
// the 64-bit finalizer hash, and every reply is compared with the oldest
// expected one.
// ----------------------------------------------------------------------------
module hkvt_checker
  import hkvt_pkg::*;
#(
  parameter int BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  logic clk,
  input  logic rst_n,
  hkvt_if      in_ch,
  hkvt_if      out_ch,
  hkvt_if      cfg_ch,
  output int   fails,
  output int   pending,
  output int   replies_seen,
  output int   full_replies
);
  localparam int SLOTS = BUCKETS * WAYS;

  logic [63:0] model_keys [SLOTS];
  logic [63:0] model_values [SLOTS];
  logic        model_valid [SLOTS];
  logic [8:0]  model_buckets;
  rsp_t        awaited_replies [$];

  function automatic logic [63:0] finalize_hash(logic [63:0] k);
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL_A;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL_B;
    k = k ^ (k >> MIX_SHIFT);
    return k;
  endfunction

  function automatic rsp_t predict_table_reply(req_t r);
    int unsigned n;
    int unsigned base;
    int unsigned hit;
    rsp_t rsp;
    n = model_buckets;
    if (n == 0) n = 1;
    if (n > BUCKETS) n = BUCKETS;
    base = int'(finalize_hash(r.key) % 64'(n)) * WAYS;
    hit = WAYS;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (model_valid[base + w] && model_keys[base + w] == r.key) hit = w;
    end
    rsp.status = ST_MISSING;
    rsp.result_value = '0;
    case (mode_t'(r.mode))
      MODE_INSERT: begin
        if (hit < WAYS) begin
          model_values[base + hit] = r.value;
          rsp.status = ST_OK;
        end else begin
          rsp.status = ST_FULL;
          for (int w = 0; w < WAYS; w++) begin
            if (rsp.status == ST_FULL && !model_valid[base + w]) begin
              model_valid[base + w] = 1'b1;
              model_keys[base + w] = r.key;
              model_values[base + w] = r.value;
              rsp.status = ST_OK;
            end
          end
        end
      end
      MODE_LOOKUP: begin
        if (hit < WAYS) begin
          rsp.result_value = model_values[base + hit];
          rsp.status = ST_OK;
        end
      end
      MODE_REMOVE: begin
        if (hit < WAYS) begin
          rsp.result_value = model_values[base + hit];
          model_valid[base + hit] = 1'b0;
          rsp.status = ST_OK;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    fails++;
  endtask

  initial begin
    fails = 0;
    replies_seen = 0;
    full_replies = 0;
  end

  assign pending = awaited_replies.size();

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) model_valid[i] = 1'b0;
      model_buckets = 9'd256;
      awaited_replies.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          report("unexpected reply status/value", '0, {got.status, got.result_value[61:0]});
        end else begin
          want = awaited_replies.pop_front();
          if (want.status == ST_FULL) full_replies++;
          if (got.status !== want.status) report("status", want.status, got.status);
          if (got.result_value !== want.result_value)
            report("result_value", want.result_value, got.result_value);
        end
      end
      if (in_ch.valid && in_ch.ready) awaited_replies.push_back(predict_table_reply(in_ch.payload));
      if (cfg_ch.valid && cfg_ch.ready) model_buckets = cfg_ch.payload;
    end
  end
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives the hashed key-value table with directed and random insert, lookup
// and remove requests over several bucket counts, with random gaps, a long
// reply stall and a drain pause; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
  import hkvt_pkg::*;

  localparam int BUCKETS = 256;
  localparam int WAYS = 4;

  logic clk;
  logic rst_n;
  int   fails, pending, replies_seen, full_replies;
  int   requests_sent, bucket_writes;
  int   reply_wait;
  bit   no_gaps, hold_replies;

  hkvt_if #(.W($bits(req_t))) in_ch ();
  hkvt_if #(.W($bits(rsp_t))) out_ch ();
  hkvt_if #(.W(9))            cfg_ch ();

  hashed_key_value_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  hkvt_checker #(.BUCKETS(BUCKETS), .WAYS(WAYS)) checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fails(fails), .pending(pending), .replies_seen(replies_seen),
    .full_replies(full_replies)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d replies outstanding", pending);
    $display("Verification failed");
    $finish;
  end

  // reply side
  initial begin
    out_ch.ready = 1'b0;
    reply_wait = 0;
    forever begin
      @(negedge clk);
      if (hold_replies) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_replies = 1'b0;
      end
      if (reply_wait > 0) begin
        out_ch.ready = 1'b0;
        reply_wait--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) reply_wait = no_gaps ? 0 : $urandom_range(0, 7);
  end

  task automatic send_request(mode_t mode, logic [63:0] key, logic [63:0] value);
    int gap;
    req_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    r.mode = mode;
    r.key = key;
    r.value = value;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.payload = r;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_bucket_count(logic [8:0] n);
    drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.payload = n;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    bucket_writes++;
  endtask

  function automatic mode_t pick_mode();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return MODE_INSERT;
    if (p < 70) return MODE_LOOKUP;
    if (p < 95) return MODE_REMOVE;
    return MODE_NONE;
  endfunction

  logic [8:0]  phase_counts [11] = '{9'd256, 9'd1, 9'd2, 9'd3, 9'd7, 9'd0,
                                     9'd511, 9'd300, 9'd64, 9'd255, 9'd256};
  logic [63:0] key_pool [16];

  initial begin
    logic [63:0] k;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = 9'd256;
    no_gaps = 1'b0;
    hold_replies = 1'b0;
    requests_sent = 0;
    bucket_writes = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // key and value extremes, every mode, hits and misses
    send_request(MODE_INSERT, 64'h0, '1);
    send_request(MODE_INSERT, '1, 64'h0);
    send_request(MODE_LOOKUP, 64'h0, 64'h0);
    send_request(MODE_LOOKUP, '1, '1);
    send_request(MODE_INSERT, 64'h0, 64'h5555_5555_5555_5555);
    send_request(MODE_LOOKUP, 64'h0, 64'h0);
    send_request(MODE_REMOVE, '1, 64'h0);
    send_request(MODE_LOOKUP, '1, 64'h0);
    send_request(MODE_REMOVE, '1, 64'h0);
    send_request(MODE_NONE, 64'h0, '1);
    send_request(MODE_LOOKUP, 64'h0, 64'h0);

    // one bucket: fill it, overflow it, overwrite inside the full bucket
    set_bucket_count(9'd1);
    for (int i = 0; i < WAYS + 1; i++)
      send_request(MODE_INSERT, 64'hA000 + i, {$urandom, $urandom});
    send_request(MODE_INSERT, 64'hA000, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(MODE_LOOKUP, 64'hA000, 64'h0);
    send_request(MODE_LOOKUP, 64'hA000 + WAYS, 64'h0);
    send_request(MODE_REMOVE, 64'hA001, 64'h0);
    send_request(MODE_INSERT, 64'hA000 + WAYS, '1);
    send_request(MODE_LOOKUP, 64'hA000 + WAYS, 64'h0);

    foreach (phase_counts[p]) begin
      set_bucket_count(phase_counts[p]);
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      for (int n = 0; n < 120; n++) begin
        no_gaps = (n >= 80 && n < 100);
        if (p == 2 && n == 30) hold_replies = 1'b1;
        if (p == 4 && n == 60) drain();
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, 15)];
        else k = {$urandom, $urandom};
        send_request(pick_mode(), k, {$urandom, $urandom});
      end
      no_gaps = 1'b0;
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    $display("%0d requests, %0d replies (%0d bucket-full), %0d bucket-count writes",
             requests_sent, replies_seen, full_replies, bucket_writes);
    $display("bucket counts swept 0..511 incl. 1 and 256, with stalls and drains");
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/hkvt_pkg.sv
rtl/core/hkvt_if.sv
rtl/core/hkvt_hash.sv
rtl/core/hashed_key_value_table.sv
dv/hkvt_checker.sv
dv/testbench.sv
